// ----- rtl/core/gtj_pkg.sv -----
// Shared types and constants for the greedy text justifier.
// No dependencies; used by gtj_divider and greedy_text_justifier.
package gtj_pkg;

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam int         WC_W       = 5;
    localparam logic [WC_W-1:0] WC_MAX = 5'd31;
    localparam logic [5:0] WIDTH_RESET = 6'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIT,
        ST_PREP,
        ST_DIV,
        ST_EMIT,
        ST_SEP,
        ST_COPY
    } t_state;

endpackage

// ----- rtl/core/gtj_divider.sv -----
// Restoring divider, one quotient bit per cycle, for the gap spacing split.
// Depends on gtj_pkg for the divisor width.
module gtj_divider #(
    parameter int DW = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DW-1:0]            i_dividend,
    input  logic [gtj_pkg::WC_W-1:0] i_divisor,
    output logic                     o_done,
    output logic [DW-1:0]            o_quot,
    output logic [gtj_pkg::WC_W-1:0] o_rem
);

    localparam int CW = (DW > 1) ? $clog2(DW) : 1;

    logic                     r_busy;
    logic                     r_done;
    logic [CW-1:0]            r_cnt;
    logic [DW-1:0]            r_q;
    logic [gtj_pkg::WC_W-1:0] r_acc;
    logic [gtj_pkg::WC_W-1:0] r_div;
    logic [gtj_pkg::WC_W:0]   trial;
    logic                     qbit;

    always_comb begin
        trial = {r_acc, r_q[DW-1]};
        qbit  = (trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_acc <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DW-2:0], qbit};
            r_acc <= qbit ? gtj_pkg::WC_W'(trial - {1'b0, r_div})
                          : gtj_pkg::WC_W'(trial);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_acc;

endmodule

// ----- rtl/core/greedy_text_justifier.sv -----
// Top level of the greedy text justifier: sequencer, word and line stores.
// Depends on gtj_pkg and gtj_divider.
//
// Characters arrive one per beat; a beat without a word end leaves the block
// ready for the next one. A word end appends the word to the line store,
// and a justified line first uses the shared divider that splits the spare
// spaces. While a line is sent the input is held off, and one character
// leaves per cycle when the output is ready. The output beat is registered,
// so the next character is taken while the last one waits.
// line_width 0 acts as 1, above MAX_WIDTH it acts as MAX_WIDTH.
module greedy_text_justifier #(
    parameter int MAX_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [5:0] i_cfg_wr_data,   // line_width
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] text_char
    input  logic       s_axis_tuser,    // [0] word_end
    input  logic       s_axis_tlast,    // text_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] out_char
    output logic [1:0] m_axis_tuser,    // [0] run_last, [1] word_cut
    output logic       m_axis_tlast     // line_end
);

    localparam int LW = $clog2(MAX_WIDTH + 1);
    localparam int IW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WCW = gtj_pkg::WC_W;

    gtj_pkg::t_state r_state, n_state;

    logic [5:0]     r_width;
    logic [LW-1:0]  r_word_len, n_word_len;
    logic           r_word_ovl, n_word_ovl;
    logic [LW-1:0]  r_line_len, n_line_len;
    logic [WCW-1:0] r_lwc, n_lwc;
    logic           r_line_cut, n_line_cut;
    logic [LW-1:0]  r_wl, n_wl;
    logic           r_cut, n_cut;
    logic           r_tend, n_tend;
    logic           r_final, n_final;
    logic           r_justify, n_justify;
    logic [LW-1:0]  r_idx, n_idx;
    logic [LW-1:0]  r_done, n_done;
    logic [WCW-1:0] r_gap, n_gap;
    logic           r_ingap, n_ingap;
    logic [LW:0]    r_gleft, n_gleft;
    logic [LW-1:0]  r_base, n_base;
    logic [WCW-1:0] r_extra, n_extra;
    logic [LW-1:0]  r_ci, n_ci;
    logic           r_ovalid, n_ovalid;
    logic [7:0]     r_odata, n_odata;
    logic           r_oend, n_oend;
    logic           r_olast, n_olast;
    logic           r_ocut, n_ocut;

    logic [7:0] r_word_mem [MAX_WIDTH];
    logic [7:0] r_line_mem [MAX_WIDTH];
    logic       r_sep      [MAX_WIDTH];

    logic          word_we;
    logic [IW-1:0] word_waddr;
    logic          line_we;
    logic [IW-1:0] line_waddr;
    logic [7:0]    line_wdata;
    logic          line_wsep;

    logic [LW-1:0]  w;
    logic           accept;
    logic           fire;
    logic           word_done;
    logic [LW-1:0]  new_word_len;
    logic           fit_break;
    logic           justify_now;
    logic           copy_more;
    logic           pad;
    logic           cur_sep;
    logic           last_beat;
    logic [LW:0]    gsp_start;
    logic [LW:0]    gap_left;
    logic [LW-1:0]  spare;
    logic           div_start;
    logic           div_done;
    logic [LW-1:0]  div_quot;
    logic [WCW-1:0] div_rem;

    gtj_divider #(
        .DW (LW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (spare),
        .i_divisor  (r_lwc - 1'b1),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_comb begin
        if (r_width == '0) begin
            w = LW'(1);
        end else if (r_width > 6'(MAX_WIDTH)) begin
            w = LW'(MAX_WIDTH);
        end else begin
            w = LW'(r_width);
        end
    end

    assign s_axis_tready = (r_state == gtj_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign fire          = !r_ovalid || m_axis_tready;
    assign word_done     = s_axis_tuser || s_axis_tlast;
    assign new_word_len  = (r_word_len < w) ? r_word_len + 1'b1 : r_word_len;
    assign fit_break     = (r_lwc != '0) &&
                           ((LW+2)'(r_line_len) + (LW+2)'(1) + (LW+2)'(r_wl)
                            > (LW+2)'(w));
    assign justify_now   = !r_final && (r_lwc > WCW'(1));
    assign copy_more     = (r_ci < r_wl) && (r_line_len < LW'(MAX_WIDTH));
    assign pad           = (r_idx >= r_line_len);
    assign cur_sep       = r_sep[r_idx[IW-1:0]];
    assign last_beat     = ((LW+1)'(r_done) + (LW+1)'(1) == (LW+1)'(w));
    assign spare         = (w > r_line_len) ? w - r_line_len : '0;
    assign gsp_start     = (LW+1)'(1) +
                           (r_justify ? (LW+1)'(r_base) + (LW+1)'(r_gap < r_extra)
                                      : '0);
    assign gap_left      = r_ingap ? r_gleft - 1'b1 : gsp_start - 1'b1;
    assign div_start     = (r_state == gtj_pkg::ST_PREP) && justify_now;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gtj_pkg::ST_IDLE: begin
                if (accept && word_done) n_state = gtj_pkg::ST_FIT;
            end
            gtj_pkg::ST_FIT: begin
                n_state = fit_break ? gtj_pkg::ST_PREP : gtj_pkg::ST_SEP;
            end
            gtj_pkg::ST_PREP: begin
                n_state = justify_now ? gtj_pkg::ST_DIV : gtj_pkg::ST_EMIT;
            end
            gtj_pkg::ST_DIV: begin
                if (div_done) n_state = gtj_pkg::ST_EMIT;
            end
            gtj_pkg::ST_EMIT: begin
                if (fire && last_beat) begin
                    n_state = r_final ? gtj_pkg::ST_IDLE : gtj_pkg::ST_SEP;
                end
            end
            gtj_pkg::ST_SEP: begin
                n_state = gtj_pkg::ST_COPY;
            end
            gtj_pkg::ST_COPY: begin
                if (!copy_more) begin
                    n_state = r_tend ? gtj_pkg::ST_PREP : gtj_pkg::ST_IDLE;
                end
            end
            default: n_state = gtj_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_word_len = r_word_len;
        n_word_ovl = r_word_ovl;
        n_line_len = r_line_len;
        n_lwc      = r_lwc;
        n_line_cut = r_line_cut;
        n_wl       = r_wl;
        n_cut      = r_cut;
        n_tend     = r_tend;
        n_final    = r_final;
        n_justify  = r_justify;
        n_idx      = r_idx;
        n_done     = r_done;
        n_gap      = r_gap;
        n_ingap    = r_ingap;
        n_gleft    = r_gleft;
        n_base     = r_base;
        n_extra    = r_extra;
        n_ci       = r_ci;
        n_ovalid   = r_ovalid && !m_axis_tready;
        n_odata    = r_odata;
        n_oend     = r_oend;
        n_olast    = r_olast;
        n_ocut     = r_ocut;
        word_we    = 1'b0;
        word_waddr = r_word_len[IW-1:0];
        line_we    = 1'b0;
        line_waddr = r_line_len[IW-1:0];
        line_wdata = r_word_mem[r_ci[IW-1:0]];
        line_wsep  = 1'b0;

        case (r_state)
            gtj_pkg::ST_IDLE: begin
                if (accept) begin
                    if (r_word_len < w) begin
                        word_we    = 1'b1;
                        n_word_len = new_word_len;
                    end else begin
                        n_word_ovl = 1'b1;
                    end
                    if (word_done) begin
                        n_wl   = (new_word_len > w) ? w : new_word_len;
                        n_cut  = (r_word_ovl || !(r_word_len < w)) || (new_word_len > w);
                        n_tend = s_axis_tlast;
                    end
                end
            end
            gtj_pkg::ST_FIT: begin
                n_final = 1'b0;
            end
            gtj_pkg::ST_PREP: begin
                n_justify = justify_now;
                n_base    = '0;
                n_extra   = '0;
                n_idx     = '0;
                n_done    = '0;
                n_gap     = '0;
                n_ingap   = 1'b0;
            end
            gtj_pkg::ST_DIV: begin
                if (div_done) begin
                    n_base  = div_quot;
                    n_extra = div_rem;
                end
            end
            gtj_pkg::ST_EMIT: begin
                if (fire) begin
                    n_ovalid = 1'b1;
                    n_ocut   = r_line_cut;
                    n_oend   = last_beat;
                    n_olast  = last_beat && (r_final || !r_tend);
                    n_odata  = gtj_pkg::SPACE_CHAR;
                    if (!pad && cur_sep) begin
                        if (gap_left == '0) begin
                            n_idx   = r_idx + 1'b1;
                            n_gap   = r_gap + 1'b1;
                            n_ingap = 1'b0;
                        end else begin
                            n_ingap = 1'b1;
                            n_gleft = gap_left;
                        end
                    end else if (!pad) begin
                        n_odata = r_line_mem[r_idx[IW-1:0]];
                        n_idx   = r_idx + 1'b1;
                    end
                    n_done = r_done + 1'b1;
                    if (last_beat) begin
                        n_line_len = '0;
                        n_lwc      = '0;
                        n_line_cut = 1'b0;
                    end
                end
            end
            gtj_pkg::ST_SEP: begin
                n_ci = '0;
                if ((r_lwc != '0) && (r_line_len < LW'(MAX_WIDTH))) begin
                    line_we    = 1'b1;
                    line_wdata = gtj_pkg::SPACE_CHAR;
                    line_wsep  = 1'b1;
                    n_line_len = r_line_len + 1'b1;
                end
            end
            gtj_pkg::ST_COPY: begin
                if (copy_more) begin
                    line_we    = 1'b1;
                    n_line_len = r_line_len + 1'b1;
                    n_ci       = r_ci + 1'b1;
                end else begin
                    if (r_lwc < gtj_pkg::WC_MAX) n_lwc = r_lwc + 1'b1;
                    n_line_cut = r_line_cut || r_cut;
                    n_word_len = '0;
                    n_word_ovl = 1'b0;
                    n_final    = 1'b1;
                end
            end
            default: begin
                n_ovalid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= gtj_pkg::ST_IDLE;
            r_width    <= gtj_pkg::WIDTH_RESET;
            r_word_len <= '0;
            r_word_ovl <= 1'b0;
            r_line_len <= '0;
            r_lwc      <= '0;
            r_line_cut <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            if (i_cfg_wr_en) r_width <= i_cfg_wr_data;
            r_word_len <= n_word_len;
            r_word_ovl <= n_word_ovl;
            r_line_len <= n_line_len;
            r_lwc      <= n_lwc;
            r_line_cut <= n_line_cut;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wl      <= n_wl;
        r_cut     <= n_cut;
        r_tend    <= n_tend;
        r_final   <= n_final;
        r_justify <= n_justify;
        r_idx     <= n_idx;
        r_done    <= n_done;
        r_gap     <= n_gap;
        r_ingap   <= n_ingap;
        r_gleft   <= n_gleft;
        r_base    <= n_base;
        r_extra   <= n_extra;
        r_ci      <= n_ci;
        r_odata   <= n_odata;
        r_oend    <= n_oend;
        r_olast   <= n_olast;
        r_ocut    <= n_ocut;
    end

    always_ff @(posedge i_clk) begin
        if (word_we) r_word_mem[word_waddr] <= s_axis_tdata;
    end

    always_ff @(posedge i_clk) begin
        if (line_we) begin
            r_line_mem[line_waddr] <= line_wdata;
            r_sep[line_waddr]      <= line_wsep;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_oend;
    assign m_axis_tuser  = {r_ocut, r_olast};

endmodule
